@@ hw/rtl/pqtd_pkg.sv @@
// pqtd_pkg: shared types, codes and constants of the tail-drop packet queue
// no dependencies; imported by pqtd_ctrl, pqtd_out and the top level
`timescale 1ns / 1ps

package pqtd_pkg;

   localparam int TAG_W        = 16;
   localparam int LEN_W        = 16;
   localparam int HOP_W        = 8;
   localparam int TIME_W       = 32;
   localparam int COUNT_W      = 7;
   localparam int BYTE_LIMIT_W = 22;
   localparam int STATUS_W     = 3;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 22;

   localparam logic                    CAPACITY_ENABLE_RESET = 1'b1;
   localparam logic [COUNT_W-1:0]      CAPACITY_LIMIT_RESET  = 7'd64;
   localparam logic [BYTE_LIMIT_W-1:0] BYTE_LIMIT_RESET      = 22'h3F_FFFF;
   localparam logic                    FIFO_MODE_RESET       = 1'b1;

   typedef enum logic {
      CMD_ENQUEUE = 1'b0,
      CMD_REQUEST = 1'b1
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ACCEPTED   = 3'd0,
      ST_DROP_LIMIT = 3'd1,
      ST_DROP_FULL  = 3'd2,
      ST_DELIVERED  = 3'd3,
      ST_EMPTY      = 3'd4
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CAPACITY_ENABLE = 2'd0,
      CSR_CAPACITY_LIMIT  = 2'd1,
      CSR_BYTE_LIMIT      = 2'd2,
      CSR_FIFO_MODE       = 2'd3
   } csr_index_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [TAG_W-1:0]   packet_tag;
      logic [LEN_W-1:0]   byte_length;
      logic [HOP_W-1:0]   hop_count_in;
      logic [TIME_W-1:0]  wait_total_in;
      logic [TIME_W-1:0]  now;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [TAG_W-1:0]   packet_tag_out;
      logic [LEN_W-1:0]   byte_length_out;
      logic [HOP_W-1:0]   hop_count_out;
      logic [COUNT_W-1:0] op_count;
      logic [TIME_W-1:0]  wait_here;
      logic [TIME_W-1:0]  wait_total_out;
      logic [COUNT_W-1:0] entries;
   } rsp_type;

   typedef struct packed {
      logic                    capacity_enable;
      logic [COUNT_W-1:0]      capacity_limit;
      logic [BYTE_LIMIT_W-1:0] byte_limit;
      logic                    fifo_mode;
   } cfg_type;

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [LEN_W-1:0]  bytes;
      logic [HOP_W-1:0]  hops;
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] wait_total;
   } slot_type;

   // transaction between the accept stage and the result stage
   typedef struct packed {
      logic               deliver;
      status_type         status;
      logic [TAG_W-1:0]   tag;
      logic [LEN_W-1:0]   len;
      logic [HOP_W-1:0]   hops;
      logic [COUNT_W-1:0] op_count;
      logic [TIME_W-1:0]  wait_total;
      logic [TIME_W-1:0]  now;
      logic [COUNT_W-1:0] entries;
   } stage_type;

   function automatic logic [HOP_W-1:0] hop_inc(input logic [HOP_W-1:0] h);
      logic [HOP_W-1:0] r;
      r = (h == '1) ? h : h + HOP_W'(1);
      return r;
   endfunction

endpackage

@@ hw/rtl/pqtd_stream_if.sv @@
// pqtd_stream_if: valid/ready channel carrying one payload struct
// payload type is given at instantiation (req_type or rsp_type from pqtd_pkg)
`timescale 1ns / 1ps

interface pqtd_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/pqtd_ram.sv @@
// pqtd_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module pqtd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/pqtd_ctrl.sv @@
// pqtd_ctrl: accept stage; head, entry count, running byte sum, drop decision,
// slot ram addressing and the stage register; depends on pqtd_pkg
`timescale 1ns / 1ps

module pqtd_ctrl import pqtd_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  logic                     req_valid,
   input  req_type                  req_payload,
   output logic                     req_ready,
   input  logic                     out_load,
   input  logic [LEN_W-1:0]         rd_bytes,
   output logic                     ram_wr_en,
   output logic [$clog2(DEPTH)-1:0] ram_wr_addr,
   output slot_type                 ram_wr_data,
   output logic                     ram_rd_en,
   output logic [$clog2(DEPTH)-1:0] ram_rd_addr,
   output logic                     s1_valid,
   output stage_type                s1
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int BW   = $clog2(DEPTH * (2 ** LEN_W - 1) + 1);
   localparam int CMPW = (CW > COUNT_W) ? CW : COUNT_W;
   localparam int BCW  = (BW > BYTE_LIMIT_W) ? BW : BYTE_LIMIT_W;
   localparam logic [AW:0]   DEPTH_SUM   = (AW + 1)'(DEPTH);
   localparam logic [CW-1:0] DEPTH_COUNT = CW'(DEPTH);
   localparam logic [AW-1:0] LAST_INDEX  = AW'(DEPTH - 1);

   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [BW-1:0] byte_total_ff, byte_total_in;
   logic          s1_valid_ff, s1_valid_in;
   stage_type     s1_ff, s1_in, stage_in;

   logic          accept, is_enq, limit_drop, full, empty, store, take, sub_now;
   logic [BW-1:0] byte_pend, byte_eff, byte_sub, byte_add;
   logic [AW:0]   tail_sum, last_sum;
   logic [AW-1:0] tail_pos, last_pos, head_next;

   assign req_ready = !s1_valid_ff || out_load;
   assign accept    = req_valid && req_ready;
   assign is_enq    = (req_payload.cmd == CMD_ENQUEUE);

   // delivery still in the stage has not yet left the byte sum
   assign byte_pend  = (s1_valid_ff && s1_ff.deliver) ? BW'(rd_bytes) : '0;
   assign byte_eff   = byte_total_ff - byte_pend;
   assign sub_now    = s1_valid_ff && s1_ff.deliver && out_load;
   assign byte_sub   = sub_now ? BW'(rd_bytes) : '0;
   assign byte_add   = store ? BW'(req_payload.byte_length) : '0;

   assign limit_drop = cfg.capacity_enable
                       && (CMPW'(count_ff) >= CMPW'(cfg.capacity_limit))
                       && (BCW'(byte_eff) > BCW'(cfg.byte_limit));
   assign full       = (count_ff == DEPTH_COUNT);
   assign empty      = (count_ff == '0);
   assign store      = accept && is_enq && !limit_drop && !full;
   assign take       = accept && !is_enq && !empty;

   assign tail_sum  = (AW + 1)'(head_ff) + (AW + 1)'(count_ff);
   assign tail_pos  = (tail_sum >= DEPTH_SUM) ? AW'(tail_sum - DEPTH_SUM) : AW'(tail_sum);
   assign last_sum  = tail_sum - (AW + 1)'(1);
   assign last_pos  = (last_sum >= DEPTH_SUM) ? AW'(last_sum - DEPTH_SUM) : AW'(last_sum);
   assign head_next = (head_ff == LAST_INDEX) ? '0 : head_ff + AW'(1);

   always_comb begin
      count_in = count_ff;
      if (store) begin
         count_in = count_ff + CW'(1);
      end else if (take) begin
         count_in = count_ff - CW'(1);
      end
      head_in       = (take && cfg.fifo_mode) ? head_next : head_ff;
      byte_total_in = byte_total_ff - byte_sub + byte_add;
   end

   assign ram_wr_en              = store;
   assign ram_wr_addr            = tail_pos;
   assign ram_wr_data.tag        = req_payload.packet_tag;
   assign ram_wr_data.bytes      = req_payload.byte_length;
   assign ram_wr_data.hops       = hop_inc(req_payload.hop_count_in);
   assign ram_wr_data.arrival    = req_payload.now;
   assign ram_wr_data.wait_total = req_payload.wait_total_in;
   assign ram_rd_en              = take;
   assign ram_rd_addr            = cfg.fifo_mode ? head_ff : last_pos;

   always_comb begin
      stage_in            = '0;
      stage_in.status     = ST_ACCEPTED;
      stage_in.tag        = req_payload.packet_tag;
      stage_in.len        = req_payload.byte_length;
      stage_in.hops       = req_payload.hop_count_in;
      stage_in.wait_total = req_payload.wait_total_in;
      stage_in.now        = req_payload.now;
      stage_in.entries    = COUNT_W'(count_in);
      if (is_enq) begin
         if (limit_drop) begin
            stage_in.status = ST_DROP_LIMIT;
         end else if (full) begin
            stage_in.status = ST_DROP_FULL;
         end else begin
            stage_in.hops     = hop_inc(req_payload.hop_count_in);
            stage_in.op_count = COUNT_W'(1);
         end
      end else if (empty) begin
         stage_in        = '0;
         stage_in.status = ST_EMPTY;
      end else begin
         stage_in.deliver  = 1'b1;
         stage_in.status   = ST_DELIVERED;
         stage_in.op_count = COUNT_W'(count_in) + COUNT_W'(1);
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_in       = stage_in;
      end else if (out_load) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         count_ff      <= '0;
         byte_total_ff <= '0;
         s1_valid_ff   <= 1'b0;
      end else begin
         head_ff       <= head_in;
         count_ff      <= count_in;
         byte_total_ff <= byte_total_in;
         s1_valid_ff   <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   assign s1_valid = s1_valid_ff;
   assign s1       = s1_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_COUNT)
      else $error("entry count above depth");

   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= LAST_INDEX)
      else $error("head index out of range");

   a_take_decrements: assert property (@(posedge clock) disable iff (reset)
      accept && !is_enq && !empty |=> count_ff == $past(count_ff) - CW'(1))
      else $error("delivery did not remove an entry");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_load |=> s1_valid_ff && s1_ff == $past(s1_ff))
      else $error("stalled stage transaction changed");

endmodule

@@ hw/rtl/pqtd_out.sv @@
// pqtd_out: result stage; merges slot ram read data, computes waits and
// drives the result register; depends on pqtd_pkg
`timescale 1ns / 1ps

module pqtd_out import pqtd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      s1_valid,
   input  stage_type s1,
   input  slot_type  rd_data,
   output logic      out_load,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_payload
);

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic [TIME_W-1:0] wait_here;
   logic [TIME_W:0]   wait_sum;

   assign out_load  = s1_valid && (!rsp_valid_ff || rsp_ready);
   assign wait_here = s1.now - rd_data.arrival;
   assign wait_sum  = {1'b0, rd_data.wait_total} + {1'b0, wait_here};

   always_comb begin
      rsp_in.status          = s1.status;
      rsp_in.packet_tag_out  = s1.tag;
      rsp_in.byte_length_out = s1.len;
      rsp_in.hop_count_out   = s1.hops;
      rsp_in.op_count        = s1.op_count;
      rsp_in.wait_here       = '0;
      rsp_in.wait_total_out  = s1.wait_total;
      rsp_in.entries         = s1.entries;
      if (s1.deliver) begin
         rsp_in.packet_tag_out  = rd_data.tag;
         rsp_in.byte_length_out = rd_data.bytes;
         rsp_in.hop_count_out   = hop_inc(rd_data.hops);
         rsp_in.wait_here       = wait_here;
         // saturate accumulated wait
         rsp_in.wait_total_out  = wait_sum[TIME_W] ? '1 : wait_sum[TIME_W-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_delivery_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == ST_DELIVERED |->
         rsp_ff.op_count == rsp_ff.entries + COUNT_W'(1))
      else $error("delivery operation count does not match entries");

   a_empty_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == ST_EMPTY |->
         rsp_ff.entries == '0 && rsp_ff.wait_here == '0)
      else $error("empty request with nonzero fields");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && rsp_ff == $past(rsp_ff))
      else $error("stalled result changed");

endmodule

@@ hw/rtl/packet_queue_tail_drop.sv @@
// packet_queue_tail_drop: top level of the tail-drop packet queue
// depends on pqtd_pkg, pqtd_stream_if, pqtd_ram, pqtd_ctrl, pqtd_out
//
// usage:
//   req_if carries one command transaction (enqueue or request) of req_type,
//   rsp_if returns exactly one rsp_type transaction for each of them, in order.
//   csr_we / csr_index / csr_wdata write the four limit and mode registers;
//   write them only while the queue has no transaction in flight.
// throughput and pipeline:
//   one transaction accepted per cycle while req_if.ready is high; the result
//   passes the stage register and slot ram read, then the result register.
// storage:
//   descriptors live in one DEPTH-entry slot ram with a registered read port;
//   the byte total is a running sum, reduced when a delivery leaves the stage.
// reset:
//   synchronous; clears head, entry count, byte total and both valid flags and
//   loads the register defaults; slot contents are not cleared.
// stall:
//   a held result keeps rsp_if.valid high; one more transaction waits in the
//   stage behind it, after which req_if.ready drops until rsp_if.ready returns.
`timescale 1ns / 1ps

module packet_queue_tail_drop import pqtd_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   pqtd_stream_if.sink            req_if,
   pqtd_stream_if.source          rsp_if,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = $clog2(DEPTH);

   cfg_type   cfg_ff, cfg_in;
   logic      ram_wr_en, ram_rd_en, out_load, s1_valid;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   slot_type  ram_wr_data, ram_rd_data;
   stage_type s1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CAPACITY_ENABLE: cfg_in.capacity_enable = csr_wdata[0];
            CSR_CAPACITY_LIMIT:  cfg_in.capacity_limit  = csr_wdata[COUNT_W-1:0];
            CSR_BYTE_LIMIT:      cfg_in.byte_limit      = csr_wdata[BYTE_LIMIT_W-1:0];
            CSR_FIFO_MODE:       cfg_in.fifo_mode       = csr_wdata[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.capacity_enable <= CAPACITY_ENABLE_RESET;
         cfg_ff.capacity_limit  <= CAPACITY_LIMIT_RESET;
         cfg_ff.byte_limit      <= BYTE_LIMIT_RESET;
         cfg_ff.fifo_mode       <= FIFO_MODE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pqtd_ram #(
      .WIDTH ($bits(slot_type)),
      .DEPTH (DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   pqtd_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_if.valid),
      .req_payload (req_if.payload),
      .req_ready   (req_if.ready),
      .out_load    (out_load),
      .rd_bytes    (ram_rd_data.bytes),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .s1_valid    (s1_valid),
      .s1          (s1)
   );

   pqtd_out u_out (
      .clock       (clock),
      .reset       (reset),
      .s1_valid    (s1_valid),
      .s1          (s1),
      .rd_data     (ram_rd_data),
      .out_load    (out_load),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .rsp_payload (rsp_if.payload)
   );

endmodule
